// File: src/sliding_median_spike_detector_top_macros.svh
// assertion macros for the sliding median spike detector
// used by sliding_median_spike_detector_top, expects clock and reset in scope
`ifndef SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_MACROS_SVH
`define SLIDING_MEDIAN_SPIKE_DETECTOR_TOP_MACROS_SVH

// same-cycle implication
`define SMSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/smsd_pkg.sv
// shared widths and default sizes for the sliding median spike detector
// no dependencies
`timescale 1ns / 1ps

package smsd_pkg;

   localparam int MAX_WINDOW_DEF = 1024;
   localparam int NUM_BINS_DEF   = 256;

   localparam int SAMPLE_W = 8;
   localparam int CFG_W    = 11;
   localparam int DM_W     = 9;
   localparam int TOTAL_W  = 32;

endpackage

// File: src/sliding_median_spike_detector_top.sv
// channel   | handshake            | payload
// req       | req_valid/req_ready  | req_sample
// rsp       | rsp_valid/rsp_ready  | rsp_median_valid, rsp_doubled_median, rsp_alert,
//           |                      | rsp_alert_total
// csr       | csr_we               | csr_wdata (window length)
//
// one item at a time; the histogram scan reads one bin per cycle from the bin memory
// full window: scan bins from bin 0 up to the median, take the oldest sample out of its bin,
// then add the new one; filling window: only add the new sample to its bin
// reset and every csr write start a clearing pass over all NUM_BINS bins, req_ready low
// a waiting result holds only the final stage; the next item is taken meanwhile
//
// sliding window median spike detector: delay store, bin histogram, scan and update
// depends on smsd_pkg and sliding_median_spike_detector_top_macros.svh
`timescale 1ns / 1ps
`include "sliding_median_spike_detector_top_macros.svh"

module sliding_median_spike_detector_top
   import smsd_pkg::*;
#(
   parameter int MAX_WINDOW = MAX_WINDOW_DEF,
   parameter int NUM_BINS   = NUM_BINS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_median_valid,
   output logic [DM_W-1:0]     rsp_doubled_median,
   output logic                rsp_alert,
   output logic [TOTAL_W-1:0]  rsp_alert_total,
   input  logic                csr_we,
   input  logic [CFG_W-1:0]    csr_wdata
);

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int POS_W = $clog2(MAX_WINDOW);
   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int DMF_W = BIN_W + 1;
   localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(NUM_BINS - 1);

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_SCAN  = 8'b0000_0100,
      S_OLD   = 8'b0000_1000,
      S_DEC   = 8'b0001_0000,
      S_INCRD = 8'b0010_0000,
      S_INC   = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [TOTAL_W-1:0] alert_cnt_ff, alert_cnt_in;
   logic [BIN_W-1:0]   samp_ff, samp_in;
   logic               full_ff, full_in;
   logic [BIN_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [LEN_W-1:0]   cum_ff, cum_in;
   logic [BIN_W-1:0]   lower_ff, lower_in;
   logic               have_lower_ff, have_lower_in;
   logic [DMF_W-1:0]   dm_ff, dm_in;
   logic [BIN_W-1:0]   clr_idx_ff, clr_idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_mv_ff, rsp_mv_in;
   logic [DM_W-1:0]    rsp_dm_ff, rsp_dm_in;
   logic               rsp_alert_ff, rsp_alert_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   // histogram memory
   logic [LEN_W-1:0] bin_mem [NUM_BINS];
   logic [LEN_W-1:0] bin_rdata_ff;
   logic             bin_rd_en;
   logic [BIN_W-1:0] bin_rd_addr;
   logic             bin_we;
   logic [BIN_W-1:0] bin_wr_addr;
   logic [LEN_W-1:0] bin_wdata;

   // delay store
   logic [BIN_W-1:0] st_mem [MAX_WINDOW];
   logic [BIN_W-1:0] st_rdata_ff;
   logic             st_rd_en;
   logic             st_we;

   logic [31:0]      wl_ext;
   logic [31:0]      samp_ext;
   logic [BIN_W-1:0] s_sat;
   logic [LEN_W-1:0] cum_sum;
   logic [LEN_W-1:0] half;
   logic             found;
   logic [BIN_W-1:0] lower_use;
   logic [DMF_W-1:0] dm_found;
   logic [LEN_W-1:0] pos_nxt;
   logic             alert_now;

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_wr_addr] <= bin_wdata;
      end
      if (bin_rd_en) begin
         bin_rdata_ff <= bin_mem[bin_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[pos_ff] <= samp_ff;
      end
      if (st_rd_en) begin
         st_rdata_ff <= st_mem[pos_ff];
      end
   end

   always_comb begin
      samp_ext = 32'(req_sample);
      if (samp_ext >= 32'(NUM_BINS)) begin
         s_sat = BIN_LAST;
      end else begin
         s_sat = BIN_W'(samp_ext);
      end

      cum_sum   = cum_ff + bin_rdata_ff;
      half      = len_ff >> 1;
      found     = cum_sum > half;
      lower_use = have_lower_ff ? lower_ff : scan_idx_ff;
      if (len_ff[0]) begin
         dm_found = {scan_idx_ff, 1'b0};
      end else begin
         dm_found = {1'b0, lower_use} + {1'b0, scan_idx_ff};
      end

      pos_nxt   = LEN_W'(pos_ff) + LEN_W'(1);
      alert_now = full_ff && ({1'b0, samp_ff} >= dm_ff);
      wl_ext    = 32'(csr_wdata);
   end

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      alert_cnt_in  = alert_cnt_ff;
      samp_in       = samp_ff;
      full_in       = full_ff;
      scan_idx_in   = scan_idx_ff;
      cum_in        = cum_ff;
      lower_in      = lower_ff;
      have_lower_in = have_lower_ff;
      dm_in         = dm_ff;
      clr_idx_in    = clr_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mv_in     = rsp_mv_ff;
      rsp_dm_in     = rsp_dm_ff;
      rsp_alert_in  = rsp_alert_ff;
      rsp_total_in  = rsp_total_ff;
      bin_rd_en     = 1'b0;
      bin_rd_addr   = '0;
      bin_we        = 1'b0;
      bin_wr_addr   = '0;
      bin_wdata     = '0;
      st_rd_en      = 1'b0;
      st_we         = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            bin_we      = 1'b1;
            bin_wr_addr = clr_idx_ff;
            if (clr_idx_ff == BIN_LAST) begin
               state_in = S_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + BIN_W'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               samp_in  = s_sat;
               st_rd_en = 1'b1;
               dm_in    = '0;
               if (fill_ff >= len_ff) begin
                  full_in       = 1'b1;
                  bin_rd_en     = 1'b1;
                  bin_rd_addr   = '0;
                  scan_idx_in   = '0;
                  cum_in        = '0;
                  lower_in      = '0;
                  have_lower_in = 1'b0;
                  state_in      = S_SCAN;
               end else begin
                  full_in     = 1'b0;
                  fill_in     = fill_ff + LEN_W'(1);
                  bin_rd_en   = 1'b1;
                  bin_rd_addr = s_sat;
                  state_in    = S_INC;
               end
            end
         end
         S_SCAN: begin
            if (!len_ff[0] && !have_lower_ff && (cum_sum == half)) begin
               have_lower_in = 1'b1;
               lower_in      = scan_idx_ff;
            end
            if (found) begin
               dm_in    = dm_found;
               state_in = S_OLD;
            end else if (scan_idx_ff == BIN_LAST) begin
               dm_in    = '0;
               state_in = S_OLD;
            end else begin
               cum_in      = cum_sum;
               scan_idx_in = scan_idx_ff + BIN_W'(1);
               bin_rd_en   = 1'b1;
               bin_rd_addr = scan_idx_ff + BIN_W'(1);
            end
         end
         S_OLD: begin
            bin_rd_en   = 1'b1;
            bin_rd_addr = st_rdata_ff;
            state_in    = S_DEC;
         end
         S_DEC: begin
            bin_we      = 1'b1;
            bin_wr_addr = st_rdata_ff;
            bin_wdata   = (bin_rdata_ff != '0) ? bin_rdata_ff - LEN_W'(1) : bin_rdata_ff;
            state_in    = S_INCRD;
         end
         S_INCRD: begin
            bin_rd_en   = 1'b1;
            bin_rd_addr = samp_ff;
            state_in    = S_INC;
         end
         S_INC: begin
            bin_we      = 1'b1;
            bin_wr_addr = samp_ff;
            bin_wdata   = bin_rdata_ff + LEN_W'(1);
            st_we       = 1'b1;
            if (pos_nxt >= len_ff) begin
               pos_in = '0;
            end else begin
               pos_in = POS_W'(pos_nxt);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (alert_now && (alert_cnt_ff != '1)) begin
                  alert_cnt_in = alert_cnt_ff + TOTAL_W'(1);
               end
               rsp_valid_in = 1'b1;
               rsp_mv_in    = full_ff;
               rsp_dm_in    = DM_W'(dm_ff);
               rsp_alert_in = alert_now;
               rsp_total_in = alert_cnt_in;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in   = S_CLEAR;
            clr_idx_in = '0;
         end
      endcase

      // new window length restarts the window
      if (csr_we) begin
         if (wl_ext == 32'd0) begin
            len_in = LEN_W'(1);
         end else if (wl_ext > 32'(MAX_WINDOW)) begin
            len_in = LEN_W'(MAX_WINDOW);
         end else begin
            len_in = LEN_W'(wl_ext);
         end
         pos_in     = '0;
         fill_in    = '0;
         clr_idx_in = '0;
         state_in   = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         len_ff       <= LEN_W'(1);
         pos_ff       <= '0;
         fill_ff      <= '0;
         alert_cnt_ff <= '0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         alert_cnt_ff <= alert_cnt_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      samp_ff       <= samp_in;
      full_ff       <= full_in;
      scan_idx_ff   <= scan_idx_in;
      cum_ff        <= cum_in;
      lower_ff      <= lower_in;
      have_lower_ff <= have_lower_in;
      dm_ff         <= dm_in;
      rsp_mv_ff     <= rsp_mv_in;
      rsp_dm_ff     <= rsp_dm_in;
      rsp_alert_ff  <= rsp_alert_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_median_valid   = rsp_mv_ff;
   assign rsp_doubled_median = rsp_dm_ff;
   assign rsp_alert          = rsp_alert_ff;
   assign rsp_alert_total    = rsp_total_ff;

   `SMSD_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= len_ff, "fill level above window length")
   `SMSD_ASSERT_NOW(a_pos_bound, 1'b1, LEN_W'(pos_ff) < len_ff,
      "write position outside window")
   `SMSD_ASSERT_NOW(a_invalid_median_zero, rsp_valid_ff && !rsp_mv_ff,
      (rsp_dm_ff == '0) && !rsp_alert_ff, "result without median carries median or alert")
   `SMSD_ASSERT_NEXT(a_scan_from_full,
      (state_ff == S_IDLE) && req_valid && !csr_we && (fill_ff >= len_ff),
      state_ff == S_SCAN, "full window item skipped the scan")

endmodule
